[hw/rtl/agkf_pkg.sv]
// ----------------------------------------------------------------------------
// agkf_pkg
// Shared types and constants of the angle / gyro-bias Kalman filter.
// ----------------------------------------------------------------------------
package agkf_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int CFG_WIDTH = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_Q = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_Q  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_R  = 2'd2;

    localparam logic [CFG_WIDTH-1:0] ANGLE_Q_RST = 31'd66;
    localparam logic [CFG_WIDTH-1:0] BIAS_Q_RST  = 31'd197;
    localparam logic [CFG_WIDTH-1:0] MEAS_R_RST  = 31'd1966;

    typedef struct packed {
        logic signed [24:0] accel_angle;
        logic signed [27:0] rate_dps;
        logic        [16:0] time_step;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] angle_estimate;
        logic signed [31:0] bias_estimate;
    } t_out_item;

    typedef enum logic {
        OP_MUL,
        OP_DIV
    } t_op;

    typedef struct packed {
        logic start;
        t_op  op;
    } t_mdu_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_WAIT,
        S_OUT
    } t_state;

    typedef enum logic [3:0] {
        ST_RATE,
        ST_PXSUM,
        ST_QA,
        ST_PBB,
        ST_QB,
        ST_K0,
        ST_K1,
        ST_ANG,
        ST_BIAS,
        ST_PBA,
        ST_PBB2,
        ST_PAA,
        ST_PAB
    } t_step;

endpackage

[hw/rtl/agkf_muldiv.sv]
// ----------------------------------------------------------------------------
// agkf_muldiv
// Bit-serial fixed-point multiply and restoring divide with saturation.
// ----------------------------------------------------------------------------
module agkf_muldiv #(
    parameter int W = agkf_pkg::DATA_WIDTH_DEF,
    parameter int F = agkf_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  agkf_pkg::t_mdu_ctl  i_ctl,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    output logic                o_done,
    output logic signed [W-1:0] o_res
);
    localparam int NW = W + F;
    localparam int CW = $clog2(NW + 1);
    localparam logic [2*W-1:0] LIM_P = {{(W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic [2*W-1:0] LIM_N = LIM_P + (2*W)'(1);

    logic                r_busy;
    logic                r_done;
    agkf_pkg::t_op       r_op;
    logic                r_neg;
    logic [CW-1:0]       r_cnt;
    logic [NW-1:0]       r_src;
    logic [2*W-1:0]      r_acc;
    logic [W-1:0]        r_rem;
    logic [W-1:0]        r_dm;

    logic [W-1:0]        mag_a;
    logic [W-1:0]        mag_b;
    logic [W:0]          rem_try;
    logic                q_bit;
    logic [2*W-1:0]      m_raw;
    logic [2*W-1:0]      m_lim;
    logic [2*W-1:0]      m_clamp;
    logic [W-1:0]        m_w;

    assign mag_a   = i_a[W-1] ? W'(-i_a) : W'(i_a);
    assign mag_b   = i_b[W-1] ? W'(-i_b) : W'(i_b);
    assign rem_try = {r_rem, r_src[NW-1]};
    assign q_bit   = (rem_try >= {1'b0, r_dm});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_op  <= i_ctl.op;
            r_neg <= i_a[W-1] ^ i_b[W-1];
            r_src <= {mag_a, {F{1'b0}}};
            r_dm  <= mag_b;
            r_acc <= '0;
            r_rem <= '0;
            r_cnt <= (i_ctl.op == agkf_pkg::OP_MUL) ? CW'(W) : CW'(NW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            r_src <= {r_src[NW-2:0], 1'b0};
            if (r_op == agkf_pkg::OP_MUL) begin
                // shift-add, multiplier bits taken MSB first
                r_acc <= {r_acc[2*W-2:0], 1'b0} + (r_src[NW-1] ? (2*W)'(r_dm) : '0);
            end else begin
                r_acc <= {r_acc[2*W-2:0], q_bit};
                r_rem <= q_bit ? W'(rem_try - {1'b0, r_dm}) : W'(rem_try);
            end
        end
    end

    always_comb begin
        m_raw   = (r_op == agkf_pkg::OP_MUL) ? (r_acc >> F) : r_acc;
        m_lim   = r_neg ? LIM_N : LIM_P;
        m_clamp = (m_raw > m_lim) ? m_lim : m_raw;
        m_w     = m_clamp[W-1:0];
        if (r_op == agkf_pkg::OP_DIV && r_dm == '0) begin
            o_res = '0;
        end else begin
            o_res = r_neg ? signed'(W'(-m_w)) : signed'(m_w);
        end
    end

    assign o_done = r_done;

endmodule

[hw/rtl/angle_gyro_bias_kalman_filter_top.sv]
// ----------------------------------------------------------------------------
// angle_gyro_bias_kalman_filter_top
// Two-state angle / gyro-bias Kalman filter on one serial multiply/divide unit.
// ----------------------------------------------------------------------------
// Each input item runs 11 multiplies and 2 divides in sequence on the serial unit
// (each one issued, stepped serially, then done), after which o_out_valid rises.
// With a zero innovation variance the update half is skipped.
// A new item is accepted only once the previous result has been delivered.
// Synchronous active-low reset restores noise registers, state and covariance.
module angle_gyro_bias_kalman_filter_top #(
    parameter int FRAC_BITS  = agkf_pkg::FRAC_BITS_DEF,
    parameter int DATA_WIDTH = agkf_pkg::DATA_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  agkf_pkg::t_in_item                  i_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output agkf_pkg::t_out_item                 o_data,
    input  logic                                i_cfg_we,
    input  logic [agkf_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [agkf_pkg::CFG_WIDTH-1:0]      i_cfg_data
);
    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int EW = W + 8;
    localparam logic signed [EW-1:0] SMAX_E = {{(EW - W + 1){1'b0}}, {(W - 1){1'b1}}};
    localparam logic signed [EW-1:0] SMIN_E = ~SMAX_E;
    localparam logic signed [EW-1:0] L32MAX_E = {{(EW - 31){1'b0}}, {31{1'b1}}};
    localparam logic signed [EW-1:0] L32MIN_E = ~L32MAX_E;
    localparam logic signed [W-1:0]  ONE_W = W'(1) << F;

    function automatic logic signed [W-1:0] sat_w(input logic signed [EW-1:0] v);
        if (v > SMAX_E) begin
            return SMAX_E[W-1:0];
        end else if (v < SMIN_E) begin
            return SMIN_E[W-1:0];
        end
        return v[W-1:0];
    endfunction

    function automatic logic signed [EW-1:0] ext(input logic signed [W-1:0] v);
        return EW'(v);
    endfunction

    function automatic logic signed [31:0] clamp32(input logic signed [W-1:0] v);
        logic signed [EW-1:0] ve;
        ve = EW'(v);
        if (ve > L32MAX_E) begin
            ve = L32MAX_E;
        end else if (ve < L32MIN_E) begin
            ve = L32MIN_E;
        end
        return ve[31:0];
    endfunction

    agkf_pkg::t_state r_state, n_state;
    agkf_pkg::t_step  r_step, n_step;

    logic [agkf_pkg::CFG_WIDTH-1:0] r_qa, r_qb, r_rm;
    agkf_pkg::t_in_item             r_in;

    logic signed [W-1:0] r_angle, n_angle;
    logic signed [W-1:0] r_bias, n_bias;
    logic signed [W-1:0] r_paa, n_paa;
    logic signed [W-1:0] r_pab, n_pab;
    logic signed [W-1:0] r_pba, n_pba;
    logic signed [W-1:0] r_pbb, n_pbb;
    logic signed [W-1:0] r_t, n_t;
    logic signed [W-1:0] r_y, n_y;
    logic signed [W-1:0] r_s, n_s;
    logic signed [W-1:0] r_k0, n_k0;
    logic signed [W-1:0] r_k1, n_k1;
    logic                r_out_valid, n_out_valid;

    agkf_pkg::t_mdu_ctl  mdu_ctl;
    logic signed [W-1:0] mdu_a, mdu_b, mdu_res;
    logic                mdu_done;

    logic signed [W-1:0] dt_w, qa_w, qb_w, rm_w;
    logic signed [EW-1:0] pe;

    assign dt_w = signed'(W'(r_in.time_step));
    assign qa_w = sat_w(signed'(EW'(r_qa)));
    assign qb_w = sat_w(signed'(EW'(r_qb)));
    assign rm_w = sat_w(signed'(EW'(r_rm)));
    assign pe   = ext(mdu_res);

    agkf_muldiv #(
        .W(W),
        .F(F)
    ) u_muldiv (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (mdu_ctl),
        .i_a    (mdu_a),
        .i_b    (mdu_b),
        .o_done (mdu_done),
        .o_res  (mdu_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= agkf_pkg::S_IDLE;
            r_step      <= agkf_pkg::ST_RATE;
            r_out_valid <= 1'b0;
            r_qa        <= agkf_pkg::ANGLE_Q_RST;
            r_qb        <= agkf_pkg::BIAS_Q_RST;
            r_rm        <= agkf_pkg::MEAS_R_RST;
            r_angle     <= '0;
            r_bias      <= '0;
            r_paa       <= ONE_W;
            r_pab       <= '0;
            r_pba       <= '0;
            r_pbb       <= ONE_W;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
            r_angle     <= n_angle;
            r_bias      <= n_bias;
            r_paa       <= n_paa;
            r_pab       <= n_pab;
            r_pba       <= n_pba;
            r_pbb       <= n_pbb;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    agkf_pkg::REG_ANGLE_Q: r_qa <= i_cfg_data;
                    agkf_pkg::REG_BIAS_Q:  r_qb <= i_cfg_data;
                    agkf_pkg::REG_MEAS_R:  r_rm <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t  <= n_t;
        r_y  <= n_y;
        r_s  <= n_s;
        r_k0 <= n_k0;
        r_k1 <= n_k1;
        if (i_in_valid && o_in_ready) begin
            r_in <= i_data;
        end
    end

    // operand select for the current step
    always_comb begin
        mdu_a = dt_w;
        mdu_b = dt_w;
        unique case (r_step)
            agkf_pkg::ST_RATE: begin
                mdu_a = sat_w(EW'(r_in.rate_dps) - ext(r_bias));
            end
            agkf_pkg::ST_PXSUM: mdu_b = sat_w(ext(r_pba) + ext(r_pab));
            agkf_pkg::ST_QA:    mdu_a = qa_w;
            agkf_pkg::ST_PBB:   mdu_b = r_pbb;
            agkf_pkg::ST_QB:    mdu_a = qb_w;
            agkf_pkg::ST_K0: begin
                mdu_a = r_paa;
                mdu_b = r_s;
            end
            agkf_pkg::ST_K1: begin
                mdu_a = r_pba;
                mdu_b = r_s;
            end
            agkf_pkg::ST_ANG: begin
                mdu_a = r_k0;
                mdu_b = r_y;
            end
            agkf_pkg::ST_BIAS: begin
                mdu_a = r_k1;
                mdu_b = r_y;
            end
            agkf_pkg::ST_PBA: begin
                mdu_a = r_k1;
                mdu_b = r_paa;
            end
            agkf_pkg::ST_PBB2: begin
                mdu_a = r_k1;
                mdu_b = r_pab;
            end
            agkf_pkg::ST_PAA: begin
                mdu_a = r_k0;
                mdu_b = r_paa;
            end
            agkf_pkg::ST_PAB: begin
                mdu_a = r_k0;
                mdu_b = r_pab;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        n_angle     = r_angle;
        n_bias      = r_bias;
        n_paa       = r_paa;
        n_pab       = r_pab;
        n_pba       = r_pba;
        n_pbb       = r_pbb;
        n_t         = r_t;
        n_y         = r_y;
        n_s         = r_s;
        n_k0        = r_k0;
        n_k1        = r_k1;
        mdu_ctl.start = 1'b0;
        mdu_ctl.op    = (r_step == agkf_pkg::ST_K0 || r_step == agkf_pkg::ST_K1)
                        ? agkf_pkg::OP_DIV : agkf_pkg::OP_MUL;
        o_in_ready  = (r_state == agkf_pkg::S_IDLE);

        unique case (r_state)
            agkf_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_step  = agkf_pkg::ST_RATE;
                    n_state = agkf_pkg::S_ISSUE;
                end
            end
            agkf_pkg::S_ISSUE: begin
                mdu_ctl.start = 1'b1;
                n_state       = agkf_pkg::S_WAIT;
            end
            agkf_pkg::S_WAIT: begin
                if (mdu_done) begin
                    n_state = agkf_pkg::S_ISSUE;
                    n_step  = agkf_pkg::t_step'(r_step + 4'd1);
                    unique case (r_step)
                        agkf_pkg::ST_RATE:  n_angle = sat_w(ext(r_angle) + pe);
                        agkf_pkg::ST_PXSUM: n_t = mdu_res;
                        agkf_pkg::ST_QA:    n_paa = sat_w(ext(r_paa) - ext(r_t) + pe);
                        agkf_pkg::ST_PBB: begin
                            n_pab = sat_w(ext(r_pab) - pe);
                            n_pba = sat_w(ext(r_pba) - pe);
                        end
                        agkf_pkg::ST_QB: begin
                            n_pbb = sat_w(ext(r_pbb) + pe);
                            n_y   = sat_w(EW'(r_in.accel_angle) - ext(r_angle));
                            n_s   = sat_w(ext(r_paa) + ext(rm_w));
                            // zero innovation variance: keep predicted values
                            if (n_s == '0) begin
                                n_state     = agkf_pkg::S_OUT;
                                n_out_valid = 1'b1;
                            end
                        end
                        agkf_pkg::ST_K0:   n_k0 = mdu_res;
                        agkf_pkg::ST_K1:   n_k1 = mdu_res;
                        agkf_pkg::ST_ANG:  n_angle = sat_w(ext(r_angle) + pe);
                        agkf_pkg::ST_BIAS: n_bias = sat_w(ext(r_bias) + pe);
                        agkf_pkg::ST_PBA:  n_pba = sat_w(ext(r_pba) - pe);
                        agkf_pkg::ST_PBB2: n_pbb = sat_w(ext(r_pbb) - pe);
                        agkf_pkg::ST_PAA:  n_paa = sat_w(ext(r_paa) - pe);
                        agkf_pkg::ST_PAB: begin
                            n_pab       = sat_w(ext(r_pab) - pe);
                            n_step      = agkf_pkg::ST_RATE;
                            n_state     = agkf_pkg::S_OUT;
                            n_out_valid = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            agkf_pkg::S_OUT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    n_state     = agkf_pkg::S_IDLE;
                end
            end
            default: n_state = agkf_pkg::S_IDLE;
        endcase
    end

    assign o_out_valid           = r_out_valid;
    assign o_data.angle_estimate = clamp32(r_angle);
    assign o_data.bias_estimate  = clamp32(r_bias);

endmodule

[hw/rtl/agkf_checker.sv]
// ----------------------------------------------------------------------------
// agkf_checker
// Port-level checks of the Kalman filter top level.
// ----------------------------------------------------------------------------
module agkf_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input agkf_pkg::t_out_item o_data
);
    // no item taken while a result is pending
    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_valid && o_in_ready && o_out_valid))
        else $error("item accepted while result pending");

    // an accepted item keeps the input closed next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready after accept");

    // a delivered result is not repeated
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready) |=> !o_out_valid)
        else $error("result repeated");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_data)))
        else $error("stalled result changed");

endmodule

bind angle_gyro_bias_kalman_filter_top agkf_checker u_agkf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_ready (o_in_ready),
    .o_out_valid(o_out_valid),
    .i_out_ready(i_out_ready),
    .o_data     (o_data)
);
